FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clock.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define RBP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every edge, reset included
`define RBP_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hw/rtl/rbp_pkg.sv
// ---------------------------------------------------------------------------
// rbp_pkg
// Types, constants and helpers of the record bitstream packer.
// ---------------------------------------------------------------------------
package rbp_pkg;

   localparam int COLUMN_W  = 4;
   localparam int ROW_W     = 5;
   localparam int SHAPE_W   = 5;
   localparam int REC_BITS  = COLUMN_W + ROW_W + SHAPE_W;
   localparam int WORD_BITS = 32;
   localparam int FILL_W    = 5;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic     has_full;
      word_type full_word;
      logic     has_flush;
      word_type flush_word;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // stream order (bit 0 at MSB) to little-endian bytes, MSB first in a byte
   function automatic word_type byte_swap(input word_type w);
      word_type r;
      r = '0;
      for (int k = 0; k < WORD_BITS / 8; k++) begin
         r[8*k +: 8] = w[WORD_BITS-1-8*k -: 8];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/rbp_interfaces.sv
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for packer requests and packed words.
// ---------------------------------------------------------------------------
interface rbp_req_if;
   logic                        valid;
   logic                        ready;
   logic [rbp_pkg::COLUMN_W-1:0] column;
   logic [rbp_pkg::ROW_W-1:0]    row;
   logic [rbp_pkg::SHAPE_W-1:0]  shape;
   logic                        last_record;

   modport source (output valid, column, row, shape, last_record, input ready);
   modport sink   (input valid, column, row, shape, last_record, output ready);
endinterface

interface rbp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rbp_pkg::WORD_BITS-1:0] packed_word;
   logic                          last_word;

   modport source (output valid, packed_word, last_word, input ready);
   modport sink   (input valid, packed_word, last_word, output ready);
endinterface

FILE: hw/rtl/rbp_front.sv
// ---------------------------------------------------------------------------
// rbp_front
// Accepts requests, appends the 14-bit record to the partial word and
// queues the completed and flushed words that result.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbp_front (
   input  logic               clock,
   input  logic               reset,
   rbp_req_if.sink            req_bus,
   input  rbp_pkg::qstat_type q_stat,
   output logic               push,
   output rbp_pkg::entry_type entry
);

   localparam int CW = 2 * rbp_pkg::WORD_BITS;

   logic [rbp_pkg::WORD_BITS-1:0] stream_ff, stream_in;
   logic [rbp_pkg::FILL_W-1:0]    fill_ff, fill_in;

   logic [rbp_pkg::REC_BITS-1:0]  rec;
   logic [CW-1:0]                 combined;
   logic [rbp_pkg::FILL_W:0]      sum;
   logic                          completes;
   logic [rbp_pkg::WORD_BITS-1:0] rest;
   logic                          accept;

   assign req_bus.ready = !q_stat.full;
   assign accept        = req_bus.valid && req_bus.ready;

   assign rec       = {req_bus.column, req_bus.row, req_bus.shape};
   assign combined  = {stream_ff, {rbp_pkg::WORD_BITS{1'b0}}}
                    | ({rec, {(CW - rbp_pkg::REC_BITS){1'b0}}} >> fill_ff);
   assign sum       = {1'b0, fill_ff} + (rbp_pkg::FILL_W + 1)'(rbp_pkg::REC_BITS);
   assign completes = sum[rbp_pkg::FILL_W];
   assign rest      = completes ? combined[rbp_pkg::WORD_BITS-1:0]
                                : combined[CW-1 -: rbp_pkg::WORD_BITS];

   always_comb begin
      entry.has_full   = completes;
      entry.full_word  = rbp_pkg::byte_swap(combined[CW-1 -: rbp_pkg::WORD_BITS]);
      entry.has_flush  = req_bus.last_record;
      entry.flush_word = rbp_pkg::byte_swap(rest);
      push             = accept && (completes || req_bus.last_record);
   end

   always_comb begin
      stream_in = stream_ff;
      fill_in   = fill_ff;
      if (accept) begin
         if (req_bus.last_record) begin
            stream_in = '0;
            fill_in   = '0;
         end else begin
            stream_in = rest;
            fill_in   = sum[rbp_pkg::FILL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ff <= '0;
         fill_ff   <= '0;
      end else begin
         stream_ff <= stream_in;
         fill_ff   <= fill_in;
      end
   end

   // records are 14 bits wide, so the fill level stays even
   `RBP_ASSERT_ALWAYS(a_fill_even, reset || !fill_ff[0], "odd fill level")

endmodule

FILE: hw/rtl/rbp_queue.sv
// ---------------------------------------------------------------------------
// rbp_queue
// Short FIFO of word entries between the front and back parts.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbp_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rbp_pkg::entry_type wr_entry,
   input  logic               pop,
   output rbp_pkg::entry_type head,
   output rbp_pkg::qstat_type q_stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   rbp_pkg::entry_type entries_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == NW'(DEPTH));
   assign head         = entries_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `RBP_ASSERT(a_no_overflow, !(push && q_stat.full), "push into full queue")
   `RBP_ASSERT(a_count_range, count_ff <= NW'(DEPTH), "queue count out of range")

endmodule

FILE: hw/rtl/rbp_back.sv
// ---------------------------------------------------------------------------
// rbp_back
// Drains queue entries to the registered output: one word per cycle if ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbp_back (
   input  logic               clock,
   input  logic               reset,
   input  rbp_pkg::entry_type head,
   input  rbp_pkg::qstat_type q_stat,
   output logic               pop,
   rbp_rsp_if.source          rsp_bus
);

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rbp_pkg::WORD_BITS-1:0] word_ff, word_in;
   logic                          last_ff, last_in;
   logic                          phase_ff, phase_in;
   logic                          load;

   assign load = !q_stat.empty && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      word_in      = word_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (head.has_full && !phase_ff) begin
            word_in = head.full_word;
            last_in = 1'b0;
            if (head.has_flush) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            word_in  = head.flush_word;
            last_in  = 1'b1;
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.packed_word = word_ff;
   assign rsp_bus.last_word   = last_ff;

   // mid-entry: the head still holds the pending flush word
   `RBP_ASSERT(a_phase_head, phase_ff |-> (!q_stat.empty && head.has_flush),
      "split entry lost its flush word")

endmodule

FILE: hw/rtl/record_bitstream_packer.sv
// A word reaches rsp through a queue entry and then the output register.
// One request per cycle while the queue has room; output drains one word per
// cycle while ready; a final request that completes a word yields two words.
// The entry queue (QUEUE_DEPTH entries) decouples packing from the output.
// Reset (synchronous) clears the partial word, fill level, queue and output.
// ---------------------------------------------------------------------------
// record_bitstream_packer
// Packs 14-bit records into 32-bit words with flush on the last record.
// ---------------------------------------------------------------------------
module record_bitstream_packer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   rbp_req_if.sink    req_bus,
   rbp_rsp_if.source  rsp_bus
);

   rbp_pkg::entry_type wr_entry;
   rbp_pkg::entry_type head;
   rbp_pkg::qstat_type q_stat;
   logic               push;
   logic               pop;

   rbp_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_stat  (q_stat),
      .push    (push),
      .entry   (wr_entry)
   );

   rbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   rbp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .q_stat  (q_stat),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

FILE: verif/rbp_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rbp_checker
// Watches the request and word channels of the record bitstream packer,
// packs every accepted record into its own copy of the bit stream and
// compares each accepted word, in order, with the oldest predicted word.
// ---------------------------------------------------------------------------
module rbp_checker (
   input  logic clock,
   input  logic reset,
   rbp_req_if   req_bus,
   rbp_rsp_if   rsp_bus,
   output int   fail_count,
   output int   pending_words,
   output int   records_seen,
   output int   words_seen,
   output int   flushes_seen,
   output int   empty_flushes,
   output int   double_words
);

   typedef struct packed {
      rbp_pkg::word_type packed_word;
      logic              last_word;
   } word_entry_type;

   word_entry_type    expected_words[$];
   rbp_pkg::word_type partial_word;
   int                fill_count;

   task automatic queue_word(input rbp_pkg::word_type w, input logic last);
      word_entry_type e;
      e.packed_word = w;
      e.last_word   = last;
      expected_words.push_back(e);
   endtask

   task automatic pack_record(input logic [rbp_pkg::COLUMN_W-1:0] column,
                              input logic [rbp_pkg::ROW_W-1:0]    row,
                              input logic [rbp_pkg::SHAPE_W-1:0]  shape,
                              input logic                         last_record);
      logic [rbp_pkg::REC_BITS-1:0] rec;
      int                           pos;
      int                           words;
      rec   = {column, row, shape};
      words = 0;
      for (int i = 0; i < rbp_pkg::REC_BITS; i++) begin
         // stream bit p goes to byte p/8, MSB first within the byte
         pos = (fill_count & 'h18) + 7 - (fill_count & 7);
         if (rec[rbp_pkg::REC_BITS-1-i]) begin
            partial_word[pos] = 1'b1;
         end
         fill_count++;
         if (fill_count == rbp_pkg::WORD_BITS) begin
            queue_word(partial_word, 1'b0);
            partial_word = '0;
            fill_count   = 0;
            words++;
         end
      end
      if (last_record) begin
         if (fill_count == 0) begin
            empty_flushes++;
         end
         queue_word(partial_word, 1'b1);
         partial_word = '0;
         fill_count   = 0;
         flushes_seen++;
         words++;
      end
      if (words == 2) begin
         double_words++;
      end
      records_seen++;
   endtask

   task automatic check_word(input rbp_pkg::word_type got_word, input logic got_last);
      word_entry_type want;
      if (expected_words.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) begin
            $display("%0t: unexpected word %08h last %b", $time, got_word, got_last);
         end
      end else begin
         want = expected_words.pop_front();
         words_seen++;
         if (got_word !== want.packed_word || got_last !== want.last_word) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display({"%0t: word mismatch: packed_word exp %08h got %08h%s,",
                         " last_word exp %b got %b%s"},
                        $time, want.packed_word, got_word,
                        (got_word !== want.packed_word) ? " (bad)" : "",
                        want.last_word, got_last,
                        (got_last !== want.last_word) ? " (bad)" : "");
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_words.delete();
         partial_word  = '0;
         fill_count    = 0;
         fail_count    = 0;
         records_seen  = 0;
         words_seen    = 0;
         flushes_seen  = 0;
         empty_flushes = 0;
         double_words  = 0;
      end else begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
            pack_record(req_bus.column, req_bus.row, req_bus.shape, req_bus.last_record);
         end
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            check_word(rsp_bus.packed_word, rsp_bus.last_word);
         end
      end
      pending_words = expected_words.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives record sequences into the record bitstream packer with random
// sender gaps and receiver stalls; a checker beside the block predicts and
// compares every packed word. Directed records cover field extremes, a word
// completing mid-record on the last record, and an exact word fill followed
// by an empty flush; random sequences of varied length follow.
// ---------------------------------------------------------------------------
module tb;

   localparam int RANDOM_RECORDS = 1830;
   localparam int QUIET_RECORDS  = 200;

   logic clock = 1'b0;
   logic reset;
   bit   quiet_phase = 1'b0;
   bit   calm_sequence = 1'b0;
   int   sent_records = 0;

   int fail_count, pending_words, records_seen, words_seen;
   int flushes_seen, empty_flushes, double_words;

   rbp_req_if req_bus ();
   rbp_rsp_if rsp_bus ();

   record_bitstream_packer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   rbp_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .records_seen  (records_seen),
      .words_seen    (words_seen),
      .flushes_seen  (flushes_seen),
      .empty_flushes (empty_flushes),
      .double_words  (double_words)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic push_record(input logic [rbp_pkg::COLUMN_W-1:0] column,
                              input logic [rbp_pkg::ROW_W-1:0]    row,
                              input logic [rbp_pkg::SHAPE_W-1:0]  shape,
                              input logic                         last_record);
      req_bus.valid       <= 1'b1;
      req_bus.column      <= column;
      req_bus.row         <= row;
      req_bus.shape       <= shape;
      req_bus.last_record <= last_record;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_records++;
   endtask

   task automatic sender_gap();
      if (!quiet_phase && !calm_sequence && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // receiver: stall bursts, with long stall-free stretches
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         if (!quiet_phase && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(50, 150)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   initial begin
      int seq_len;
      int random_sent;
      bit drained_mid;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.column      <= '0;
      req_bus.row         <= '0;
      req_bus.shape       <= '0;
      req_bus.last_record <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes, each flushed alone
      push_record(4'h0, 5'h00, 5'h00, 1'b1);
      push_record(4'hF, 5'h1F, 5'h1F, 1'b1);
      // third record crosses a word boundary and then flushes the remainder
      push_record(4'hA, 5'h15, 5'h0A, 1'b0);
      sender_gap();
      push_record(4'h5, 5'h0A, 5'h15, 1'b0);
      push_record(4'hF, 5'h1F, 5'h1F, 1'b1);
      // sixteen records end exactly on a word: full word, then empty flush
      for (int k = 0; k < 16; k++) begin
         if (k[0]) begin
            push_record(4'h5, 5'h0A, 5'h15, k == 15);
         end else begin
            push_record(4'hA, 5'h15, 5'h0A, k == 15);
         end
      end
      wait_for_drain();

      random_sent = 0;
      drained_mid = 1'b0;
      while (random_sent < RANDOM_RECORDS) begin
         case ($urandom_range(0, 9))
            0:       seq_len = 16 * $urandom_range(1, 3);
            1:       seq_len = 1;
            2:       seq_len = $urandom_range(25, 60);
            default: seq_len = $urandom_range(2, 24);
         endcase
         calm_sequence = ($urandom_range(0, 4) == 0);
         for (int k = 0; k < seq_len; k++) begin
            quiet_phase = (random_sent >= RANDOM_RECORDS - QUIET_RECORDS);
            sender_gap();
            push_record((rbp_pkg::COLUMN_W)'($urandom),
                        (rbp_pkg::ROW_W)'($urandom),
                        (rbp_pkg::SHAPE_W)'($urandom),
                        k == seq_len - 1);
            random_sent++;
         end
         if (!drained_mid && random_sent >= RANDOM_RECORDS / 2) begin
            drained_mid = 1'b1;
            wait_for_drain();
         end
      end

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
      repeat (10) @(posedge clock);

      $display("Run covered %0d records in sequences of 1 to 60, %0d words checked,",
               records_seen, words_seen);
      $display("%0d flushes (%0d empty), %0d records giving two words.",
               flushes_seen, empty_flushes, double_words);
      if (fail_count == 0 && pending_words == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d words never seen", fail_count, pending_words);
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout after %0d records sent", sent_records);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
